### design/rhc_pkg.sv
// ============================================================================
// rhc_pkg - shared types and constants for the RGB to HLS converter
// Channel and divider widths, max-channel codes and stage payload structs.
// ============================================================================
package rhc_pkg;

	localparam int CHAN_W   = 8;
	localparam int CHAN_MAX = 255;

	// long-division datapath: 17-bit dividend covers 510 * 252 + 255
	localparam int DIV_NW = 17;
	localparam int DIV_DW = 9;

	// lightness: (sum * scale + 255) / 510 as a reciprocal product,
	// ceil(2^26 / 510); exact for dividends below 132626
	localparam int LIGHT_RECIP = 131587;
	localparam int LIGHT_SHIFT = 26;

	localparam logic [1:0] MAX_RED   = 2'd0;
	localparam logic [1:0] MAX_GREEN = 2'd1;
	localparam logic [1:0] MAX_BLUE  = 2'd2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [DIV_NW-1:0] num_t;
	typedef logic [DIV_DW-1:0] den_t;

	typedef struct packed {
		logic       valid;
		logic       achro;
		logic [1:0] max_sel;
		chan_t      light;
	} side_t;

	typedef struct packed {
		num_t  sat_num;
		den_t  sat_den;
		num_t  rd_num;
		num_t  gd_num;
		num_t  bd_num;
		den_t  spread_den;
		side_t side;
	} div_req_t;

	typedef struct packed {
		chan_t hue;
		chan_t lightness;
		chan_t saturation;
	} res_t;

endpackage

### design/rhc_rgb_if.sv
// ============================================================================
// rhc_rgb_if - pixel channel
// Valid/ready channel carrying one 8-bit RGB pixel per transfer.
// ============================================================================
interface rhc_rgb_if;
	logic          valid;
	logic          ready;
	rhc_pkg::chan_t red;
	rhc_pkg::chan_t green;
	rhc_pkg::chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/rhc_hls_if.sv
// ============================================================================
// rhc_hls_if - HLS result channel
// Valid/ready channel carrying hue, lightness and saturation per transfer.
// ============================================================================
interface rhc_hls_if;
	logic          valid;
	logic          ready;
	rhc_pkg::chan_t hue;
	rhc_pkg::chan_t lightness;
	rhc_pkg::chan_t saturation;

	modport source (output valid, output hue, output lightness, output saturation,
		input ready);
	modport sink   (input valid, input hue, input lightness, input saturation,
		output ready);
endinterface

### design/rgb_to_hls_converter.sv
// ============================================================================
// rgb_to_hls_converter - RGB pixel to hue/lightness/saturation
// Top level: front stages, division pipeline, hue stage and output skid.
// ============================================================================
// Usage:
//   pixel  : valid/ready sink, one 8-bit RGB pixel per transfer.
//   result : valid/ready source, hue, lightness and saturation on a
//            0..HLS_SCALE scale, one result per pixel, in order.
//   Throughput is one pixel per clock cycle while pixel.ready is high. From
//   the pixel transfer to result.valid, a pixel passes four front stages,
//   a 17-stage restoring divider (one quotient bit per stage) and the hue
//   stage, with the output register behind them.
//   Grey pixels give saturation 0 and hue HLS_SCALE*2/3.
//   Reset clears all valid bits; the pipeline is empty and ready after it.
//   When the receiver stalls, the output register holds its result and one
//   more result drops into a skid register; only then does pixel.ready go
//   low and the whole pipeline freeze until the skid register drains.
// ============================================================================
module rgb_to_hls_converter #(
	parameter int HLS_SCALE = 240
) (
	input  logic      clk,
	input  logic      arst_n,
	rhc_rgb_if.sink   pixel,
	rhc_hls_if.source result
);

	logic              en;
	rhc_pkg::div_req_t req;
	rhc_pkg::side_t    side_q [rhc_pkg::DIV_NW];
	rhc_pkg::num_t     sat_quo, rd_quo, gd_quo, bd_quo;
	logic              fin_valid;
	rhc_pkg::res_t     fin;
	logic              out_v_q, skid_v_q, out_free;
	rhc_pkg::res_t     out_q, skid_q;

	assign en          = !skid_v_q;
	assign pixel.ready = en;
	assign out_free    = !out_v_q || result.ready;

	rhc_prep #(.HLS_SCALE(HLS_SCALE)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pixel.valid),
		.red      (pixel.red),
		.green    (pixel.green),
		.blue     (pixel.blue),
		.req      (req)
	);

	rhc_div #(.NW(rhc_pkg::DIV_NW), .DW(rhc_pkg::DIV_DW)) u_div_sat (
		.clk(clk), .en(en), .num(req.sat_num), .den(req.sat_den), .quo(sat_quo)
	);
	rhc_div #(.NW(rhc_pkg::DIV_NW), .DW(rhc_pkg::DIV_DW)) u_div_rd (
		.clk(clk), .en(en), .num(req.rd_num), .den(req.spread_den), .quo(rd_quo)
	);
	rhc_div #(.NW(rhc_pkg::DIV_NW), .DW(rhc_pkg::DIV_DW)) u_div_gd (
		.clk(clk), .en(en), .num(req.gd_num), .den(req.spread_den), .quo(gd_quo)
	);
	rhc_div #(.NW(rhc_pkg::DIV_NW), .DW(rhc_pkg::DIV_DW)) u_div_bd (
		.clk(clk), .en(en), .num(req.bd_num), .den(req.spread_den), .quo(bd_quo)
	);

	// sideband follows the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rhc_pkg::DIV_NW; i++) begin
				side_q[i] <= '0;
			end
		end else if (en) begin
			side_q[0] <= req.side;
			for (int i = 1; i < rhc_pkg::DIV_NW; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	rhc_hue #(.HLS_SCALE(HLS_SCALE)) u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.side      (side_q[rhc_pkg::DIV_NW-1]),
		.sat_quo   (sat_quo),
		.rd_quo    (rd_quo),
		.gd_quo    (gd_quo),
		.bd_quo    (bd_quo),
		.fin_valid (fin_valid),
		.fin       (fin)
	);

	// output register with one-deep skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (fin_valid && !out_free) begin
			skid_v_q <= 1'b1;
		end else if (out_free) begin
			out_v_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (result.ready) begin
				out_q <= skid_q;
			end
		end else if (fin_valid && !out_free) begin
			skid_q <= fin;
		end else if (out_free) begin
			out_q <= fin;
		end
	end

	assign result.valid      = out_v_q;
	assign result.hue        = out_q.hue;
	assign result.lightness  = out_q.lightness;
	assign result.saturation = out_q.saturation;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while output register is empty");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && result.ready |=> !skid_v_q && out_v_q)
		else $error("skid result not moved to output after transfer");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.hue <= rhc_pkg::chan_t'(HLS_SCALE)
			&& out_q.lightness <= rhc_pkg::chan_t'(HLS_SCALE)
			&& out_q.saturation <= rhc_pkg::chan_t'(HLS_SCALE))
		else $error("result field above scale");

endmodule

### design/rhc_prep.sv
// ============================================================================
// rhc_prep - front stages of the converter
// Max/min, sum/spread and deltas, scaled products, then rounded dividends
// and divisors for the division pipeline and the lightness by reciprocal
// multiplication. Four register stages.
// ============================================================================
module rhc_prep #(
	parameter int HLS_SCALE = 240
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  rhc_pkg::chan_t    red,
	input  rhc_pkg::chan_t    green,
	input  rhc_pkg::chan_t    blue,
	output rhc_pkg::div_req_t req
);

	localparam int SIXTH   = HLS_SCALE / 6;
	localparam int LOW_LIM = 2 * rhc_pkg::CHAN_MAX * (HLS_SCALE / 2 + 1);

	// stage 1
	logic           v_s1;
	rhc_pkg::chan_t r_s1, g_s1, b_s1, hi_s1, lo_s1;
	logic [1:0]     max_sel_s1;
	// stage 2
	logic           v_s2;
	rhc_pkg::den_t  sum_s2;
	rhc_pkg::chan_t spread_s2, dr_s2, dg_s2, db_s2;
	logic [1:0]     max_sel_s2;
	// stage 3
	logic           v_s3, achro_s3;
	rhc_pkg::den_t  sum_s3;
	rhc_pkg::chan_t spread_s3;
	rhc_pkg::num_t  light_num_s3, spr_x_s3, drx_s3, dgx_s3, dbx_s3;
	logic [1:0]     max_sel_s3;
	// stage 4
	logic           v_s4, achro_s4;
	logic [1:0]     max_sel_s4;
	rhc_pkg::chan_t light_s4;
	rhc_pkg::num_t  sat_num_s4, rd_num_s4, gd_num_s4, bd_num_s4;
	rhc_pkg::den_t  sat_den_s4, spread_den_s4;

	rhc_pkg::chan_t hi_c, lo_c;
	logic [1:0]     max_sel_c;
	logic           low_c;
	rhc_pkg::den_t  sat_den_c;
	logic [33:0]    light_prod_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			max_sel_c = rhc_pkg::MAX_RED;
			hi_c      = red;
		end else if (green >= blue) begin
			max_sel_c = rhc_pkg::MAX_GREEN;
			hi_c      = green;
		end else begin
			max_sel_c = rhc_pkg::MAX_BLUE;
			hi_c      = blue;
		end
		lo_c = (red < green) ? red : green;
		if (blue < lo_c) begin
			lo_c = blue;
		end
	end

	always_comb begin
		low_c        = light_num_s3 < rhc_pkg::num_t'(LOW_LIM);
		sat_den_c    = low_c ? sum_s3 : rhc_pkg::den_t'(2 * rhc_pkg::CHAN_MAX) - sum_s3;
		light_prod_c = 34'(light_num_s3) * 34'(rhc_pkg::LIGHT_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1       <= red;
			g_s1       <= green;
			b_s1       <= blue;
			hi_s1      <= hi_c;
			lo_s1      <= lo_c;
			max_sel_s1 <= max_sel_c;

			sum_s2     <= rhc_pkg::den_t'(hi_s1) + rhc_pkg::den_t'(lo_s1);
			spread_s2  <= hi_s1 - lo_s1;
			dr_s2      <= hi_s1 - r_s1;
			dg_s2      <= hi_s1 - g_s1;
			db_s2      <= hi_s1 - b_s1;
			max_sel_s2 <= max_sel_s1;

			sum_s3       <= sum_s2;
			spread_s3    <= spread_s2;
			achro_s3     <= (spread_s2 == '0);
			light_num_s3 <= rhc_pkg::num_t'(sum_s2) * rhc_pkg::num_t'(HLS_SCALE)
				+ rhc_pkg::num_t'(rhc_pkg::CHAN_MAX);
			spr_x_s3     <= rhc_pkg::num_t'(spread_s2) * rhc_pkg::num_t'(HLS_SCALE);
			drx_s3       <= rhc_pkg::num_t'(dr_s2) * rhc_pkg::num_t'(SIXTH);
			dgx_s3       <= rhc_pkg::num_t'(dg_s2) * rhc_pkg::num_t'(SIXTH);
			dbx_s3       <= rhc_pkg::num_t'(db_s2) * rhc_pkg::num_t'(SIXTH);
			max_sel_s3   <= max_sel_s2;

			light_s4      <= light_prod_c[rhc_pkg::LIGHT_SHIFT +: rhc_pkg::CHAN_W];
			sat_den_s4    <= sat_den_c;
			sat_num_s4    <= spr_x_s3 + rhc_pkg::num_t'(sat_den_c >> 1);
			rd_num_s4     <= drx_s3 + rhc_pkg::num_t'(spread_s3 >> 1);
			gd_num_s4     <= dgx_s3 + rhc_pkg::num_t'(spread_s3 >> 1);
			bd_num_s4     <= dbx_s3 + rhc_pkg::num_t'(spread_s3 >> 1);
			spread_den_s4 <= rhc_pkg::den_t'(spread_s3);
			achro_s4      <= achro_s3;
			max_sel_s4    <= max_sel_s3;
		end
	end

	always_comb begin
		req.sat_num      = sat_num_s4;
		req.sat_den      = sat_den_s4;
		req.rd_num       = rd_num_s4;
		req.gd_num       = gd_num_s4;
		req.bd_num       = bd_num_s4;
		req.spread_den   = spread_den_s4;
		req.side.valid   = v_s4;
		req.side.achro   = achro_s4;
		req.side.max_sel = max_sel_s4;
		req.side.light   = light_s4;
	end

endmodule

### design/rhc_div.sv
// ============================================================================
// rhc_div - pipelined restoring divider
// One quotient bit per stage, NW stages.
// ============================================================================
module rhc_div #(
	parameter int NW = 17,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_q [NW-1];
	logic [DW-1:0] den_q [NW-1];
	logic [NW-1:0] nq_q  [NW];

	genvar k;
	for (k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] rem_in, den_in;
		logic [NW-1:0] nq_in;
		logic [DW:0]   trial, diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = den;
			assign nq_in  = num;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign nq_in  = nq_q[k-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[k] <= {nq_in[NW-2:0], ge};
			end
		end

		if (k < NW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
					den_q[k] <= den_in;
				end
			end
		end
	end

	assign quo = nq_q[NW-1];

endmodule

### design/rhc_hue.sv
// ============================================================================
// rhc_hue - final stage
// Combines per-channel quotients into hue with wrap, applies the grey-pixel
// case and registers the finished result.
// ============================================================================
module rhc_hue #(
	parameter int HLS_SCALE = 240
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  rhc_pkg::side_t side,
	input  rhc_pkg::num_t  sat_quo,
	input  rhc_pkg::num_t  rd_quo,
	input  rhc_pkg::num_t  gd_quo,
	input  rhc_pkg::num_t  bd_quo,
	output logic           fin_valid,
	output rhc_pkg::res_t  fin
);

	localparam logic signed [9:0] SCALE_S = 10'(HLS_SCALE);
	localparam logic signed [9:0] THIRD_S = 10'(HLS_SCALE / 3);
	localparam logic signed [9:0] TWO3_S  = 10'(HLS_SCALE * 2 / 3);
	localparam rhc_pkg::chan_t    GREY_HUE = rhc_pkg::chan_t'(HLS_SCALE * 2 / 3);

	logic signed [9:0] rd_e, gd_e, bd_e, hue_raw, hue_pos, hue_fin;
	rhc_pkg::res_t     res_c;
	logic              v_s1;
	rhc_pkg::res_t     res_s1;

	assign rd_e = {2'b00, rd_quo[7:0]};
	assign gd_e = {2'b00, gd_quo[7:0]};
	assign bd_e = {2'b00, bd_quo[7:0]};

	always_comb begin
		unique case (side.max_sel)
			rhc_pkg::MAX_RED:   hue_raw = bd_e - gd_e;
			rhc_pkg::MAX_GREEN: hue_raw = THIRD_S + rd_e - bd_e;
			rhc_pkg::MAX_BLUE:  hue_raw = TWO3_S + gd_e - rd_e;
			default:            hue_raw = '0;
		endcase
		hue_pos = (hue_raw < 0) ? hue_raw + SCALE_S : hue_raw;
		hue_fin = (hue_pos > SCALE_S) ? hue_pos - SCALE_S : hue_pos;

		res_c.lightness  = side.light;
		res_c.hue        = side.achro ? GREY_HUE : hue_fin[7:0];
		res_c.saturation = side.achro ? '0 : sat_quo[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= side.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= res_c;
		end
	end

	assign fin_valid = v_s1;
	assign fin       = res_s1;

endmodule
